>>> sv/iopb_pkg.sv
// Shared types and constants for the I/O port permission bitmap.
// Used by the channel interfaces, the controller, the datapath and the top level.
package iopb_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TASK_W  = 2;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned WIDTH_W = 8;
  localparam int unsigned STS_W   = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_GRANT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DENY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

  // status codes
  localparam logic [STS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STS_W-1:0] STS_RANGE  = 2'd1;
  localparam logic [STS_W-1:0] STS_DENIED = 2'd2;
  localparam logic [STS_W-1:0] STS_WIDTH  = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STEP,
    S_MOD,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;  // write one all-ones byte of the clearing pass
    logic load;      // capture the request word
    logic rd;        // read the current bitmap byte
    logic modify;    // write back or test the byte, advance to the next one
    logic out_load;  // move the status into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // last byte of the clearing pass
    logic pre_fail;  // request word fails the kind/width/range/task tests
    logic more;      // bytes left in the range
    logic out_free;  // output register can take a word this cycle
  } sts_t;

endpackage

>>> sv/iopb_if.sv
// Request and response channel interfaces: valid/ready handshake plus payload.
// Depends on iopb_pkg for field widths.
interface iopb_req_if import iopb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [TASK_W-1:0]  task_index;
  logic [PORT_W-1:0]  port;
  logic [WIDTH_W-1:0] width;

  modport source (output valid, kind, task_index, port, width, input ready);
  modport sink   (input valid, kind, task_index, port, width, output ready);
endinterface

interface iopb_rsp_if import iopb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

>>> sv/io_port_permission_bitmap.sv
// I/O port permission bitmap, one bitmap per task, one bit per port (1 = denied).
// A request word grants (clears) or denies (sets) a run of ports, or checks an
// access of 1, 2 or 4 ports, and always returns exactly one status word:
// 0 ok, 1 range out of bounds (port+width reaches NUM_PORTS, or no such task),
// 2 access denied, 3 unsupported width or kind. After reset the block runs a
// clearing pass that sets every byte of the bitmap RAM to all ones, one byte
// per cycle, NUM_TASKS*NUM_PORTS/8 bytes (32768 by default); no request is
// taken meanwhile. One request is worked at a time through the byte-wide RAM:
// after acceptance, each bitmap byte the range touches is read and then written
// back or tested, and the status word then moves to the output register once
// it is free; a rejected request goes straight to that last step. A finished
// status word sits in the output register, so the next request is accepted
// while it waits to be taken.
// Depends on iopb_pkg, iopb_if, iopb_ctrl and iopb_dp.
module io_port_permission_bitmap import iopb_pkg::*; #(
  parameter int unsigned NUM_TASKS = 4,
  parameter int unsigned NUM_PORTS = 65536
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  iopb_req_if.sink   req_i,
  iopb_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // controller: sequencing only, no payload
  iopb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: RAM, masks, status, output register
  iopb_dp #(
    .NUM_TASKS (NUM_TASKS),
    .NUM_PORTS (NUM_PORTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (req_i.kind),
    .task_index_i (req_i.task_index),
    .port_i       (req_i.port),
    .width_i      (req_i.width),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .status_o     (rsp_o.status)
  );

endmodule

>>> sv/iopb_ctrl.sv
// Sequencer for the permission bitmap: clearing pass, request intake,
// per-byte read-modify-write steps and result hand-off. Depends on iopb_pkg.
module iopb_ctrl import iopb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = sts_i.pre_fail ? S_DONE : S_STEP;
      end
      S_STEP: begin
        state_d = sts_i.more ? S_MOD : S_DONE;
      end
      S_MOD: begin
        state_d = S_STEP;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: cmd_o.clr_step = 1'b1;
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_STEP:  cmd_o.rd = sts_i.more;
      S_MOD:   cmd_o.modify = 1'b1;
      S_DONE:  cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> sv/iopb_dp.sv
// Datapath: bitmap RAM, request registers, byte mask, status and output register.
// Depends on iopb_pkg; driven by iopb_ctrl through cmd_t / sts_t.
module iopb_dp import iopb_pkg::*; #(
  parameter int unsigned NUM_TASKS = 4,
  parameter int unsigned NUM_PORTS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [TASK_W-1:0]  task_index_i,
  input  logic [PORT_W-1:0]  port_i,
  input  logic [WIDTH_W-1:0] width_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [STS_W-1:0]   status_o
);

  localparam int unsigned BYTES_PER_TASK = NUM_PORTS / 8;
  localparam int unsigned STORE_BYTES    = NUM_TASKS * BYTES_PER_TASK;
  localparam int unsigned AW             = $clog2(STORE_BYTES);
  localparam int unsigned FULL_W         = ((AW > 16) ? AW : 16) + 1;
  localparam int unsigned POS_W          = PORT_W + 1;

  logic [7:0] mem_q [STORE_BYTES];

  logic [AW-1:0]     clr_cnt_q;
  logic [KIND_W-1:0] kind_q;
  logic [TASK_W-1:0] task_q;
  logic [POS_W-1:0]  s_q;   // first port still to do
  logic [POS_W-1:0]  e_q;   // one past the last port
  logic [AW-1:0]     addr_q;
  logic              oob_q;
  logic [7:0]        rdata_q;
  logic [STS_W-1:0]  st_q;
  logic              out_valid_q;
  logic [STS_W-1:0]  out_status_q;

  logic [POS_W-1:0]  end_in;
  logic [STS_W-1:0]  pre_code;
  logic [FULL_W-1:0] full_addr;
  logic              full_oob;
  logic [7:0]        mask;
  logic [7:0]        byte_eff;
  logic [7:0]        byte_new;

  // up-front tests on the incoming word
  always_comb begin
    end_in = POS_W'(port_i) + POS_W'(width_i);
    if (kind_i == KIND_RSVD) begin
      pre_code = STS_WIDTH;
    end else if (kind_i == KIND_CHECK && width_i != 8'd1 && width_i != 8'd2
                 && width_i != 8'd4) begin
      pre_code = STS_WIDTH;
    end else if (end_in >= POS_W'(NUM_PORTS)) begin
      pre_code = STS_RANGE;
    end else if (7'(task_index_i) >= 7'(NUM_TASKS)) begin
      pre_code = STS_RANGE;
    end else begin
      pre_code = STS_OK;
    end
  end

  // byte address of the current position, and bits of that byte in range
  always_comb begin
    full_addr = FULL_W'(task_q) * FULL_W'(BYTES_PER_TASK) + FULL_W'(s_q[POS_W-1:3]);
    full_oob  = full_addr >= FULL_W'(STORE_BYTES);
    mask      = 8'hFF << s_q[2:0];
    if (e_q[POS_W-1:3] == s_q[POS_W-1:3]) begin
      mask = mask & ~(8'hFF << e_q[2:0]);
    end
    byte_eff = oob_q ? 8'hFF : rdata_q;
    byte_new = (kind_q == KIND_DENY) ? (byte_eff | mask) : (byte_eff & ~mask);
  end

  assign sts_o.clr_last = (clr_cnt_q == AW'(STORE_BYTES - 1));
  assign sts_o.pre_fail = (pre_code != STS_OK);
  assign sts_o.more     = (s_q < e_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // bitmap RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem_q[clr_cnt_q] <= 8'hFF;
    end else if (cmd_i.modify && kind_q != KIND_CHECK && !oob_q) begin
      mem_q[addr_q] <= byte_new;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[full_addr[AW-1:0]];
    end
  end

  // request payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      task_q <= task_index_i;
      s_q    <= POS_W'(port_i);
      e_q    <= end_in;
      st_q   <= pre_code;
    end else if (cmd_i.modify) begin
      s_q <= {s_q[POS_W-1:3] + 14'd1, 3'b000};
      if (kind_q == KIND_CHECK && (byte_eff & mask) != 8'h00) begin
        st_q <= STS_DENIED;
      end
    end
    if (cmd_i.rd) begin
      addr_q <= full_addr[AW-1:0];
      oob_q  <= full_oob;
    end
    if (cmd_i.out_load) begin
      out_status_q <= st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

endmodule
